/* rtl/nbe_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package nbe_pkg;

   localparam int MAX_BYTES_DEF = 32;
   localparam int GROUP_BITS    = 5;
   localparam int SYMBOL_W      = 7;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   function automatic logic [SYMBOL_W-1:0] nix_char(input logic [GROUP_BITS-1:0] grp);
      logic [SYMBOL_W-1:0] c;
      case (grp)
         5'd0:    c = 7'h30;
         5'd1:    c = 7'h31;
         5'd2:    c = 7'h32;
         5'd3:    c = 7'h33;
         5'd4:    c = 7'h34;
         5'd5:    c = 7'h35;
         5'd6:    c = 7'h36;
         5'd7:    c = 7'h37;
         5'd8:    c = 7'h38;
         5'd9:    c = 7'h39;
         5'd10:   c = 7'h61;
         5'd11:   c = 7'h62;
         5'd12:   c = 7'h63;
         5'd13:   c = 7'h64;
         5'd14:   c = 7'h66;
         5'd15:   c = 7'h67;
         5'd16:   c = 7'h68;
         5'd17:   c = 7'h69;
         5'd18:   c = 7'h6a;
         5'd19:   c = 7'h6b;
         5'd20:   c = 7'h6c;
         5'd21:   c = 7'h6d;
         5'd22:   c = 7'h6e;
         5'd23:   c = 7'h70;
         5'd24:   c = 7'h71;
         5'd25:   c = 7'h72;
         5'd26:   c = 7'h73;
         5'd27:   c = 7'h76;
         5'd28:   c = 7'h77;
         5'd29:   c = 7'h78;
         5'd30:   c = 7'h79;
         5'd31:   c = 7'h7a;
         default: c = 7'h30;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

/* rtl/nbe_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module nbe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

/* rtl/nix_base32_encoder_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                                         Handshake
// request   req_data_byte, req_end_of_message             start && !busy
// response  rsp_symbol, rsp_final_symbol, rsp_overflow    rsp_valid, one cycle, no stall
//
// A non-final byte is taken and the block is ready again the next cycle.
// A final byte starts a run of ceil(8n/5) characters, one per cycle, and the block is
// busy for the whole run; the single read port of the byte store is read ahead,
// one byte for every eight bits consumed, so the run never pauses.
// Synchronous reset empties the store (count and overflow cleared) and ends any run.
// The receiver cannot stall; requests are held off only by busy during a run.

module nix_base32_encoder_core
   import nbe_pkg::*;
#(
   parameter int MAX_BYTES = MAX_BYTES_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [7:0]          req_data_byte,
   input  wire logic                req_end_of_message,
   output logic                     rsp_valid,
   output logic [SYMBOL_W-1:0]      rsp_symbol,
   output logic                     rsp_final_symbol,
   output logic                     rsp_overflow
);

   localparam int ADDR_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
   localparam int CNT_W  = $clog2(MAX_BYTES + 1);
   localparam int PW     = $clog2(8 * MAX_BYTES + 5);
   localparam int IW     = PW - 3;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [PW-1:0]     tlen_ff, tlen_in;
   logic [2:0]        slack_ff, slack_in;
   logic              drop_ff, drop_in;
   logic              fresh_ff, fresh_in;
   logic [PW-1:0]     pos_ff, pos_in;
   logic [ADDR_W-1:0] cur_ff, cur_in;
   logic [7:0]        hi_ff, hi_in;
   logic [7:0]        lo_ff, lo_in;

   logic              wr_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;

   logic              accept;
   logic              full;
   logic [7:0]        hi_eff, lo_eff;
   logic [15:0]       shifted;
   logic [PW-1:0]     pos_next;
   logic              last;
   logic              need_read;

   nbe_ram #(
      .WIDTH (8),
      .DEPTH (MAX_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (req_data_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign accept    = start && (state_ff == ST_IDLE);
   assign full      = (count_ff == CNT_W'(MAX_BYTES));
   assign hi_eff    = fresh_ff ? lo_ff : hi_ff;
   assign lo_eff    = fresh_ff ? rd_data : lo_ff;
   assign shifted   = {hi_eff, lo_eff} >> pos_ff[2:0];
   assign last      = (pos_ff == '0);
   assign pos_next  = pos_ff - PW'(GROUP_BITS);
   assign need_read = (pos_next[PW-1:3] != IW'(cur_ff));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_end_of_message) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy             = (state_ff == ST_EMIT);
      rsp_valid        = (state_ff == ST_EMIT);
      rsp_symbol       = nix_char(shifted[GROUP_BITS-1:0]);
      rsp_final_symbol = last;
      rsp_overflow     = drop_ff;
   end

   always_comb begin
      count_in = count_ff;
      tlen_in  = tlen_ff;
      slack_in = slack_ff;
      drop_in  = drop_ff;
      fresh_in = fresh_ff;
      pos_in   = pos_ff;
      cur_in   = cur_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      wr_en    = 1'b0;
      rd_addr  = cur_ff - ADDR_W'(1);
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!full) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
                  // keep 5*len and its slack over 8n in step with the byte count
                  if (slack_ff < 3'd3) begin
                     tlen_in  = tlen_ff + PW'(2 * GROUP_BITS);
                     slack_in = slack_ff + 3'd2;
                  end else begin
                     tlen_in  = tlen_ff + PW'(GROUP_BITS);
                     slack_in = slack_ff - 3'd3;
                  end
               end else begin
                  drop_in = 1'b1;
               end
               if (req_end_of_message) begin
                  pos_in = tlen_in - PW'(GROUP_BITS);
                  hi_in  = 8'h00;
                  if (!full) begin
                     lo_in    = req_data_byte;
                     cur_in   = count_ff[ADDR_W-1:0];
                     fresh_in = 1'b0;
                  end else begin
                     lo_in    = 8'h00;
                     cur_in   = ADDR_W'(MAX_BYTES - 1);
                     rd_addr  = ADDR_W'(MAX_BYTES - 1);
                     fresh_in = 1'b1;
                  end
               end
            end
         end
         ST_EMIT: begin
            hi_in    = hi_eff;
            lo_in    = lo_eff;
            fresh_in = 1'b0;
            if (last) begin
               count_in = '0;
               tlen_in  = '0;
               slack_in = '0;
               drop_in  = 1'b0;
            end else begin
               pos_in = pos_next;
               if (need_read) begin
                  cur_in   = cur_ff - ADDR_W'(1);
                  fresh_in = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         tlen_ff  <= '0;
         slack_ff <= '0;
         drop_ff  <= 1'b0;
         fresh_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         tlen_ff  <= tlen_in;
         slack_ff <= slack_in;
         drop_ff  <= drop_in;
         fresh_ff <= fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      cur_ff <= cur_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
   end

endmodule

`default_nettype wire

/* rtl/nbe_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module nbe_checker
   import nbe_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                start,
   input wire logic                busy,
   input wire logic                req_end_of_message,
   input wire logic                rsp_valid,
   input wire logic                rsp_final_symbol,
   input wire logic                rsp_overflow
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !busy)
      else $error("busy after reset");

   a_final_starts_run: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_end_of_message) |=> (busy && rsp_valid))
      else $error("final request did not start a run");

   a_plain_no_run: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_end_of_message) |=> !busy)
      else $error("non-final request started a run");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_final_symbol) |=> (rsp_valid && $stable(rsp_overflow)))
      else $error("run broke off or overflow changed");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_final_symbol) |=> !busy)
      else $error("still busy after final symbol");

endmodule

bind nix_base32_encoder_core nbe_checker u_nbe_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .req_end_of_message (req_end_of_message),
   .rsp_valid          (rsp_valid),
   .rsp_final_symbol   (rsp_final_symbol),
   .rsp_overflow       (rsp_overflow)
);

`default_nettype wire
